FILE: hdl/pfc_pkg.sv
// Package for the Pareto fitness comparator.
// Holds payload structs and fixed constants; no dependencies.
package pfc_pkg;

    localparam logic [31:0] Q_ONE     = 32'h0001_0000;
    localparam logic [30:0] RATIO_MAX = 31'h7FFF_FFFF;
    localparam int          ADDR_W    = 1;
    localparam logic [ADDR_W-1:0] REG_MASK = 1'b0;

    typedef struct packed {
        logic signed [31:0] value_a;
        logic signed [31:0] value_b;
        logic               strict;
        logic               last_objective;
    } in_req_t;

    typedef struct packed {
        logic signed [31:0] worst_value;
        logic               summary_valid;
        logic               a_dominates;
        logic               a_better_in_one;
        logic [31:0]        distance_epsilon;
        logic [30:0]        ratio_epsilon;
    } out_req_t;

endpackage

FILE: hdl/pareto_fitness_comparator_unit.sv
// Pareto fitness comparator: one objective pair per request, summary on the last.
// Each request passes setup, 48 division steps and a fold; the last request also takes 32
// square-root steps. A new request is accepted only once the previous one has left ST_OUT,
// so the single bit-serial divider and root loop never work on two requests at once.
// Reset (aresetn, synchronous, active low) clears the mask and per-vector state.
// Depends on pfc_pkg and pfc_divider.
module pareto_fitness_comparator_unit #(
    parameter int MAX_OBJECTIVES = 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  pfc_pkg::in_req_t    s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output pfc_pkg::out_req_t   m_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [pfc_pkg::ADDR_W+1:0] paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    localparam logic [2:0] IDX_LAST = 3'(MAX_OBJECTIVES - 1);

    typedef enum logic [2:0] {ST_IDLE, ST_DIV, ST_ROOT, ST_OUT} state_t;

    state_t      state_reg;
    logic [7:0]  mask_reg;
    logic [2:0]  idx_reg;
    logic        worse_reg, sbetter_reg, noworse_reg;
    logic [63:0] sum_reg;
    logic [31:0] ratio_reg;
    pfc_pkg::in_req_t  req_reg;
    pfc_pkg::out_req_t out_reg;
    logic              out_valid_reg;
    logic        worst_b_reg;
    // root loop
    logic [63:0] rx_reg;
    logic [63:0] rres_reg;
    logic [63:0] rbit_reg;

    logic        div_start;
    logic        div_done;
    logic signed [48:0] div_q;

    // The divider latches its operands at the accept edge, straight from the input.
    pfc_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (s_data.value_a),
        .den     (s_data.value_b),
        .done    (div_done),
        .quot    (div_q)
    );

    // Direction compare for the incoming request.
    logic               maximise;
    logic signed [32:0] d;
    logic               b_better, a_sbetter;
    assign maximise  = mask_reg[idx_reg];
    assign d         = 33'(s_data.value_b) - 33'(s_data.value_a);
    assign b_better  = maximise ? (d > 0) : (d < 0);
    assign a_sbetter = maximise ? (d < 0) : (d > 0);

    // Squared difference: one 32x32 multiply on the magnitude.
    logic signed [32:0] diff;
    logic [32:0]        mag;
    logic [63:0]        sq;
    logic [64:0]        sum_add;
    assign diff    = 33'(req_reg.value_a) - 33'(req_reg.value_b);
    assign mag     = diff[32] ? -diff : diff;
    assign sq      = mag[31:0] * mag[31:0];
    logic [63:0] sq_full;
    assign sq_full = mag[32] ? 64'h4000_0000_0000_0000 : sq;
    assign sum_add = {1'b0, sum_reg} + {1'b0, sq_full};

    logic [30:0] q_sat;
    assign q_sat = (div_q > 49'sd2147483647) ? pfc_pkg::RATIO_MAX : div_q[30:0];

    logic [63:0] rtry;
    assign rtry = rres_reg + rbit_reg;

    // Post a finished request once the output register is free or being drained.
    logic out_load;
    assign out_load = (state_reg == ST_OUT) && (!out_valid_reg || m_ready);

    assign s_ready = (state_reg == ST_IDLE);
    assign pready  = 1'b1;
    assign prdata  = {24'd0, mask_reg};
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;
    assign div_start = (state_reg == ST_IDLE) && s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            mask_reg      <= '0;
            idx_reg       <= '0;
            worse_reg     <= 1'b0;
            sbetter_reg   <= 1'b0;
            noworse_reg   <= 1'b0;
            sum_reg       <= '0;
            ratio_reg     <= pfc_pkg::Q_ONE;
            out_valid_reg <= 1'b0;
        end else begin
            if (psel && penable && pwrite && paddr[pfc_pkg::ADDR_W+1:2] == pfc_pkg::REG_MASK) begin
                mask_reg <= pwdata[7:0];
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_valid && m_ready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid && s_ready) begin
                        req_reg     <= s_data;
                        worst_b_reg <= !b_better;
                        if (b_better) worse_reg <= 1'b1;
                        if (a_sbetter) sbetter_reg <= 1'b1;
                        if (!b_better) noworse_reg <= 1'b1;
                        if (idx_reg < IDX_LAST) idx_reg <= idx_reg + 3'd1;
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        // fold in ratio (negative quotients never raise it) and the
                        // saturating square sum
                        if (req_reg.value_b != 0 && !div_q[48] &&
                            {1'b0, q_sat} > ratio_reg) begin
                            ratio_reg <= {1'b0, q_sat};
                        end
                        sum_reg <= sum_add[64] ? '1 : sum_add[63:0];
                        if (req_reg.last_objective) begin
                            rx_reg    <= sum_add[64] ? '1 : sum_add[63:0];
                            rres_reg  <= '0;
                            rbit_reg  <= 64'h4000_0000_0000_0000;
                            state_reg <= ST_ROOT;
                        end else begin
                            state_reg <= ST_OUT;
                        end
                    end
                end
                ST_ROOT: begin
                    // one root digit per cycle
                    if (rx_reg >= rtry) begin
                        rx_reg   <= rx_reg - rtry;
                        rres_reg <= (rres_reg >> 1) + rbit_reg;
                    end else begin
                        rres_reg <= rres_reg >> 1;
                    end
                    rbit_reg <= rbit_reg >> 2;
                    if (rbit_reg == 64'd1) state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    // hold here while the previous result still waits
                    if (out_load) begin
                        out_reg.worst_value <= worst_b_reg ? req_reg.value_b
                                                           : req_reg.value_a;
                        out_reg.summary_valid <= req_reg.last_objective;
                        if (req_reg.last_objective) begin
                            out_reg.a_dominates <= !worse_reg &&
                                                   (!req_reg.strict || sbetter_reg);
                            out_reg.a_better_in_one <= req_reg.strict ? sbetter_reg
                                                                      : noworse_reg;
                            out_reg.distance_epsilon <= worse_reg ? rres_reg[31:0] : '0;
                            out_reg.ratio_epsilon    <= ratio_reg[30:0];
                            // drop per-vector state
                            idx_reg     <= '0;
                            worse_reg   <= 1'b0;
                            sbetter_reg <= 1'b0;
                            noworse_reg <= 1'b0;
                            sum_reg     <= '0;
                            ratio_reg   <= pfc_pkg::Q_ONE;
                        end else begin
                            out_reg.a_dominates      <= 1'b0;
                            out_reg.a_better_in_one  <= 1'b0;
                            out_reg.distance_epsilon <= '0;
                            out_reg.ratio_epsilon    <= '0;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule

FILE: hdl/pfc_divider.sv
// Restoring divider, one quotient bit per cycle, for the ratio (a*2^16)/b.
// Depends on nothing but the clock; truncates toward zero. Saturation at RATIO_MAX is done by the comparator unit.
module pfc_divider (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [31:0] num,
    input  logic signed [31:0] den,
    output logic               done,
    output logic signed [48:0] quot
);
    logic [47:0] dividend_reg, dividend_next;
    logic [31:0] divisor_reg, divisor_next;
    logic [32:0] rem_reg, rem_next;
    logic [47:0] q_reg, q_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        neg_reg, neg_next;
    logic        done_reg, done_next;
    logic [32:0] shifted;
    logic [32:0] trial;
    logic [31:0] mag_a;
    logic [31:0] mag_b;

    assign mag_a = num[31] ? (~num + 32'd1) : num;
    assign mag_b = den[31] ? (~den + 32'd1) : den;
    assign shifted = {rem_reg[31:0], dividend_reg[47]};
    assign trial = shifted - {1'b0, divisor_reg};

    always_comb begin
        dividend_next = dividend_reg;
        divisor_next  = divisor_reg;
        rem_next      = rem_reg;
        q_next        = q_reg;
        cnt_next      = cnt_reg;
        busy_next     = busy_reg;
        neg_next      = neg_reg;
        done_next     = 1'b0;
        if (start) begin
            dividend_next = {mag_a, 16'd0};
            divisor_next  = mag_b;
            rem_next      = '0;
            q_next        = '0;
            cnt_next      = 6'd48;
            busy_next     = 1'b1;
            neg_next      = num[31] ^ den[31];
        end else if (busy_reg) begin
            dividend_next = {dividend_reg[46:0], 1'b0};
            if (!trial[32]) begin
                rem_next = trial;
                q_next   = {q_reg[46:0], 1'b1};
            end else begin
                rem_next = shifted;
                q_next   = {q_reg[46:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        dividend_reg <= dividend_next;
        divisor_reg  <= divisor_next;
        rem_reg      <= rem_next;
        q_reg        <= q_next;
        neg_reg      <= neg_next;
    end

    assign done = done_reg;
    assign quot = neg_reg ? -$signed({1'b0, q_reg}) : $signed({1'b0, q_reg});
endmodule

FILE: tb/sv/pfc_checker.sv
// Checker for the Pareto fitness comparator: watches both request channels,
// predicts each result from its own copy of the per-vector state, and counts mismatches.
// Depends on pfc_pkg.
module pfc_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  pfc_pkg::in_req_t   s_data,
    input  logic               m_valid,
    input  logic               m_ready,
    input  pfc_pkg::out_req_t  m_data,
    input  logic [7:0]         mask,
    output int                 fail_count,
    output int                 pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LAST_OBJ = 7;

    pfc_pkg::out_req_t expected_results[$];
    logic [2:0]  obj_idx;
    logic        worse_seen, better_seen, no_worse_seen;
    logic [63:0] sq_sum;
    logic [63:0] ratio_max_seen;

    function automatic logic [63:0] int_sqrt(input logic [63:0] x);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= res + b) begin
                x = x - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    task automatic predict_comparison(input pfc_pkg::in_req_t r);
        logic signed [63:0] a, b, d, q;
        logic [63:0] mag, sq, s;
        logic maxim;
        pfc_pkg::out_req_t o;
        a = 64'(r.value_a);
        b = 64'(r.value_b);
        maxim = mask[obj_idx];
        d = maxim ? (b - a) : (a - b);
        o = '0;
        o.worst_value = (d > 0) ? r.value_a : r.value_b;
        if (d > 0) worse_seen = 1;
        if (d < 0) better_seen = 1;
        if (d <= 0) no_worse_seen = 1;
        if (b != 0) begin
            q = (a * 64'sd65536) / b;
            if (q > 64'sd2147483647) q = 64'sd2147483647;
            if (q > $signed(ratio_max_seen)) ratio_max_seen = q;
        end
        mag = (a - b < 0) ? -(a - b) : (a - b);
        sq = mag * mag;
        s = sq_sum + sq;
        sq_sum = (s < sq_sum) ? 64'hFFFF_FFFF_FFFF_FFFF : s;
        if (obj_idx < LAST_OBJ) obj_idx = obj_idx + 1;
        if (r.last_objective) begin
            o.summary_valid = 1;
            o.a_dominates = !worse_seen && (!r.strict || better_seen);
            o.a_better_in_one = r.strict ? better_seen : no_worse_seen;
            o.distance_epsilon = worse_seen ? 32'(int_sqrt(sq_sum)) : 32'd0;
            o.ratio_epsilon = ratio_max_seen[30:0];
            obj_idx = 0; worse_seen = 0; better_seen = 0; no_worse_seen = 0;
            sq_sum = 0; ratio_max_seen = 64'(pfc_pkg::Q_ONE);
        end
        expected_results.push_back(o);
    endtask

    assign pending = expected_results.size();

    always @(posedge aclk) begin
        pfc_pkg::out_req_t e;
        if (!aresetn) begin
            obj_idx = 0; worse_seen = 0; better_seen = 0; no_worse_seen = 0;
            sq_sum = 0; ratio_max_seen = 64'(pfc_pkg::Q_ONE);
            expected_results.delete();
            fail_count = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) $display("unexpected result %h", m_data);
                end else begin
                    e = expected_results.pop_front();
                    if (e !== m_data) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: exp w=%h sv=%b d=%b b=%b dist=%h r=%h | got w=%h sv=%b d=%b b=%b dist=%h r=%h",
                                e.worst_value, e.summary_valid, e.a_dominates,
                                e.a_better_in_one, e.distance_epsilon, e.ratio_epsilon,
                                m_data.worst_value, m_data.summary_valid, m_data.a_dominates,
                                m_data.a_better_in_one, m_data.distance_epsilon,
                                m_data.ratio_epsilon);
                    end
                end
            end
            if (s_valid && s_ready) predict_comparison(s_data);
        end
    end
endmodule

FILE: tb/sv/tb.sv
// Testbench top for pareto_fitness_comparator_unit: drives requests and mask writes,
// applies random gaps and back-pressure, and reports the verdict.
// Depends on pfc_pkg, pfc_checker and the unit under test.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic aclk, aresetn;
    logic s_valid, s_ready, m_valid, m_ready;
    pfc_pkg::in_req_t  s_data;
    pfc_pkg::out_req_t m_data;
    logic psel, penable, pwrite, pready;
    logic [pfc_pkg::ADDR_W+1:0] paddr;
    logic [31:0] pwdata, prdata;
    logic [7:0] mask_shadow;
    int fail_count, pending;
    bit stall_long;   // request a long receiver hold-off

    pareto_fitness_comparator_unit dut (.*);

    pfc_checker chk (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data, .m_valid, .m_ready, .m_data,
        .mask(mask_shadow), .fail_count, .pending
    );

    initial begin
        aclk = 0;
        forever #6 aclk = ~aclk;
    end

    // Generous limit: covers the root loop on last requests plus long gaps and stalls.
    initial begin
        #(12ns * 3000000);
        $display("pareto_fitness_comparator_unit test failed");
        $finish;
    end

    // Gap length: mostly short, occasionally long.
    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 90) return $urandom_range(1, 4);
        return $urandom_range(20, 120);
    endfunction

    // Receiver: random stalls, with one long hold-off on request.
    initial begin
        int n;
        m_ready = 0;
        @(posedge aclk iff aresetn);
        forever begin
            if (stall_long) begin
                m_ready <= 0;
                repeat (400) @(posedge aclk);
                stall_long = 0;
            end
            n = gap_len();
            if (n > 0) begin
                m_ready <= 0;
                repeat (n) @(posedge aclk);
            end
            m_ready <= 1;
            @(posedge aclk);
        end
    end

    task automatic write_mask(input logic [7:0] m);
        // Setup phase, then access; the register loads at the access edge.
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= {pfc_pkg::REG_MASK, 2'b00};
        pwdata <= {24'd0, m};
        @(posedge aclk);
        penable <= 1;
        @(posedge aclk);
        mask_shadow = m;
        psel <= 0; penable <= 0; pwrite <= 0;
        @(posedge aclk);
    endtask

    // Send one request, holding valid and payload until accepted.
    task automatic send_req(input logic [31:0] a, input logic [31:0] b,
                            input logic st, input logic lst, input bit gaps);
        int n;
        n = gaps ? gap_len() : 0;
        if (n > 0) begin
            s_valid <= 0;
            repeat (n) @(posedge aclk);
        end
        s_valid <= 1;
        s_data <= '{value_a: a, value_b: b, strict: st, last_objective: lst};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic drain();
        s_valid <= 0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'h7FFF_FFFF - $urandom_range(0, 2);
            2: return 32'h8000_0000 + $urandom_range(0, 2);
            3: return $urandom_range(0, 3) << 16;
            4: return 32'($signed($urandom_range(0, 1024)) - 512);
            default: return {{12{$urandom_range(0, 1) == 1}}, 20'($urandom)};
        endcase
    endfunction

    initial begin
        int len, sent;
        logic [31:0] a, b;
        logic [7:0] masks[4];
        bit long_done;
        aresetn = 0; s_valid = 0; s_data = '0; stall_long = 0; long_done = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        mask_shadow = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed: extremes, ties, zero divisor, dominance both ways.
        write_mask(8'h00);
        send_req(32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0);
        send_req(32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0);
        send_req(32'h0001_0000, 32'h0000_0000, 1, 1, 0);   // zero divisor
        send_req(32'h0001_0000, 32'h0001_0000, 1, 1, 0);   // tie, strict
        send_req(32'h0001_0000, 32'h0001_0000, 0, 1, 0);   // tie, weak
        send_req(32'h0000_0001, 32'h0000_0005, 1, 0, 0);
        send_req(32'h0000_0002, 32'h0000_0002, 1, 1, 0);   // A dominates strictly
        send_req(32'h8000_0000, 32'hFFFF_FFFF, 0, 1, 0);   // ratio saturates
        send_req(32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0);
        send_req(32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0);
        send_req(32'h7FFF_FFFF, 32'h8000_0000, 0, 1, 0);   // square sum saturates
        // Too many objectives: eleven in one vector.
        for (int i = 0; i < 11; i++)
            send_req($urandom, $urandom, 1, i == 10, 0);
        drain();
        write_mask(8'hFF);
        send_req(32'h0000_0005, 32'h0000_0001, 1, 1, 0);
        send_req(32'hFFFF_0000, 32'h0002_0000, 0, 1, 0);
        drain();

        masks = '{8'h00, 8'hFF, 8'hA5, 8'h00};
        sent = 0;
        for (int ph = 0; ph < 4; ph++) begin
            write_mask(ph == 3 ? 8'($urandom) : masks[ph]);
            while (sent < (ph + 1) * 335) begin
                if (ph == 1 && sent >= 400 && !long_done) begin
                    stall_long = 1;   // fill up, stall input
                    long_done = 1;
                end
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 12)
                                                  : $urandom_range(1, 8);
                for (int i = 0; i < len; i++) begin
                    a = rand_value();
                    b = ($urandom_range(0, 3) == 0) ? a : rand_value();
                    send_req(a, b, $urandom_range(0, 1), i == len - 1, 1);
                    sent++;
                end
            end
            drain();   // sender pauses until every result is back
        end

        if (fail_count == 0)
            $display("pareto_fitness_comparator_unit test passed");
        else
            $display("pareto_fitness_comparator_unit test failed");
        $finish;
    end
endmodule
